/* rtl/tcp_reno_congestion_sender_core_macros.svh */
// ----------------------------------------------------------------------------
// tcp reno congestion sender core assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef TCP_RENO_CONGESTION_SENDER_CORE_MACROS_SVH
`define TCP_RENO_CONGESTION_SENDER_CORE_MACROS_SVH

// same-cycle implication
`define TRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcp reno sender check failed");

// next-cycle implication
`define TRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcp reno sender check failed");

`endif

/* rtl/tcprc_pkg.sv */
// ----------------------------------------------------------------------------
// tcprc_pkg
// shared codes, sizes and types of the reno congestion sender
// ----------------------------------------------------------------------------
package tcprc_pkg;

    localparam int QDEPTH  = 32;
    localparam int QIDX_W  = 5;
    localparam int CNT_W   = 6;
    localparam int SEQ_W   = 32;
    localparam int LEN_W   = 10;
    localparam logic [LEN_W-1:0] MAX_SEG = 10'd1000;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_ACK   = 2'd1;
    localparam logic [1:0] REQ_TMO   = 2'd2;

    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] MODE_SS = 2'd0;
    localparam logic [1:0] MODE_CA = 2'd1;
    localparam logic [1:0] MODE_FR = 2'd2;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_SEG   = 2'd1;
    localparam logic [1:0] CFG_THR   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/tcprc_ram.sv */
// ----------------------------------------------------------------------------
// tcprc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tcprc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcprc_div.sv */
// ----------------------------------------------------------------------------
// tcprc_div
// bit-serial restoring divider giving floor(2^(2F) / divisor)
// ----------------------------------------------------------------------------
module tcprc_div #(
    parameter int WIN_W     = 22,
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WIN_W-1:0]         divisor,
    output logic [2*FRAC_BITS:0]     quotient,
    output tcprc_pkg::div_stat_t     status
);

    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [WIN_W-1:0]  d_reg, d_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [WIN_W:0]    trial;
    logic              dbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        dbit      = (cnt_reg == CW'(QW));
        trial     = {rem_reg, dbit};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = '0;
            d_next    = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = WIN_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIN_W-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/tcp_reno_congestion_sender_core.sv */
// ----------------------------------------------------------------------------
// tcp_reno_congestion_sender_core
// reno congestion engine: start, ack and timeout events in, segment commands out
// ----------------------------------------------------------------------------
// One event is taken at a time; in_stall is high until its last result is
// loaded into the output register. A start event issues its new segments one
// after another. A duplicate ack takes one window step and a retiring ack one
// step per retired segment before any new segments go out; a step in congestion
// avoidance waits on the bit-serial reciprocal divider. The segment queue lives
// in a 32-entry ram with registered read at the queue head.
module tcp_reno_congestion_sender_core #(
    parameter int MAX_WINDOW = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] ack_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] seq_out,
    output logic [9:0]  length_out,
    output logic        last,
    output logic [1:0]  mode_out,
    output logic [5:0]  window_whole,
    output logic        done_res
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1) + FRAC_BITS;
    localparam int THR_W = 7 + FRAC_BITS;
    localparam int XW    = WIN_W + 8;
    localparam int QW    = 2 * FRAC_BITS + 1;
    localparam int SW    = tcprc_pkg::SEQ_W;
    localparam int LW    = tcprc_pkg::LEN_W;
    localparam int QI    = tcprc_pkg::QIDX_W;
    localparam int CN    = tcprc_pkg::CNT_W;
    localparam logic [XW-1:0] ONE_X  = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] WMAX_X = XW'(MAX_WINDOW) << FRAC_BITS;
    localparam logic [WIN_W-1:0] ONE_FX  = WIN_W'(ONE_X);
    localparam logic [WIN_W-1:0] WMAX_FX = WIN_W'(WMAX_X);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FRONT = 4'd1;
    localparam logic [3:0] S_RCHK  = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_RDW   = 4'd5;
    localparam logic [3:0] S_FILL  = 4'd6;
    localparam logic [3:0] S_RTX   = 4'd7;
    localparam logic [3:0] S_STAT  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [SW-1:0]    ack_reg, ack_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic [1:0]       dup_reg, dup_next;
    logic [1:0]       mode_reg, mode_next;
    logic [SW-1:0]    nseq_reg, nseq_next;
    logic [SW-1:0]    bleft_reg, bleft_next;
    logic [QI-1:0]    head_reg, head_next;
    logic [CN-1:0]    count_reg, count_next;
    logic             retire_reg, retire_next;
    logic             sent_reg, sent_next;
    logic [SW-1:0]    total_reg;
    logic [LW-1:0]    segsz_reg;
    logic [6:0]       ithr_reg;

    logic             ov_reg, ov_next;
    logic [1:0]       kind_reg, kind_next;
    logic [SW-1:0]    oseq_reg, oseq_next;
    logic [LW-1:0]    olen_reg, olen_next;
    logic             olast_reg, olast_next;
    logic [1:0]       omode_reg, omode_next;
    logic [5:0]       owin_reg, owin_next;
    logic             odone_reg, odone_next;

    logic                  ram_we;
    logic [QI-1:0]         ram_waddr;
    logic [SW+LW-1:0]      ram_rdata;
    logic [SW-1:0]         front_seq;
    logic [LW-1:0]         front_len;
    logic                  div_start;
    logic [QW-1:0]         div_q;
    tcprc_pkg::div_stat_t  div_stat;

    logic             in_acc, out_free;
    logic [LW-1:0]    seg, flen;
    logic             fcond, fnext;
    logic [SW-1:0]    bafter;
    logic [XW-1:0]    wsum, thr_half, rsum, qsum;
    logic [WIN_W-1:0] w_inc, w_rec, w_thr, w_div;
    logic [5:0]       wwhole;

    assign front_seq = ram_rdata[SW+LW-1:LW];
    assign front_len = ram_rdata[LW-1:0];
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    tcprc_ram #(.WIDTH(SW + LW), .DEPTH(tcprc_pkg::QDEPTH)) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({nseq_reg, flen}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    tcprc_div #(.WIN_W(WIN_W), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (win_reg),
        .quotient (div_q),
        .status   (div_stat)
    );

    // saturated window candidates
    always_comb
    begin
        wsum     = XW'(win_reg) + ONE_X;
        w_inc    = (wsum > WMAX_X) ? WMAX_FX : WIN_W'(wsum);
        thr_half = XW'(win_reg >> 1);
        rsum     = thr_half + XW'(3) * ONE_X;
        w_rec    = (rsum > WMAX_X) ? WMAX_FX : WIN_W'(rsum);
        w_thr    = (XW'(thr_reg) > WMAX_X) ? WMAX_FX : WIN_W'(thr_reg);
        qsum     = (div_q > QW'(WMAX_X)) ? WMAX_X + ONE_X : XW'(div_q) + XW'(win_reg);
        w_div    = (qsum > WMAX_X) ? WMAX_FX : WIN_W'(qsum);
        wwhole   = 6'(XW'(win_reg) >> FRAC_BITS);
    end

    // segment issue conditions
    always_comb
    begin
        seg    = (segsz_reg > tcprc_pkg::MAX_SEG) ? tcprc_pkg::MAX_SEG : segsz_reg;
        flen   = (bleft_reg < SW'(seg)) ? LW'(bleft_reg) : seg;
        bafter = bleft_reg - SW'(flen);
        fcond  = ((XW'(count_reg) << FRAC_BITS) < XW'(win_reg))
                 && (count_reg < CN'(tcprc_pkg::QDEPTH)) && (flen != '0);
        fnext  = ((XW'(count_reg + CN'(1)) << FRAC_BITS) < XW'(win_reg))
                 && ((count_reg + CN'(1)) < CN'(tcprc_pkg::QDEPTH)) && (bafter != '0);
        ram_waddr = head_reg + count_reg[QI-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        ack_next    = ack_reg;
        win_next    = win_reg;
        thr_next    = thr_reg;
        dup_next    = dup_reg;
        mode_next   = mode_reg;
        nseq_next   = nseq_reg;
        bleft_next  = bleft_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        retire_next = retire_reg;
        sent_next   = sent_reg;
        ov_next     = ov_reg && out_stall;
        kind_next   = kind_reg;
        oseq_next   = oseq_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        omode_next  = omode_reg;
        owin_next   = owin_reg;
        odone_next  = odone_reg;
        ram_we      = 1'b0;
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ack_next  = ack_number;
                    sent_next = 1'b0;
                    if (req_type == tcprc_pkg::REQ_START)
                    begin
                        win_next   = ONE_FX;
                        thr_next   = THR_W'(ithr_reg) << FRAC_BITS;
                        dup_next   = '0;
                        mode_next  = tcprc_pkg::MODE_SS;
                        nseq_next  = '0;
                        bleft_next = total_reg;
                        head_next  = '0;
                        count_next = '0;
                        state_next = S_FILL;
                    end
                    else if (req_type == tcprc_pkg::REQ_ACK && count_reg != '0)
                    begin
                        state_next = S_FRONT;
                    end
                    else if (req_type == tcprc_pkg::REQ_TMO && count_reg != '0)
                    begin
                        thr_next   = THR_W'(win_reg >> 1);
                        win_next   = ONE_FX;
                        dup_next   = '0;
                        mode_next  = tcprc_pkg::MODE_SS;
                        state_next = S_RTX;
                    end
                    else
                    begin
                        state_next = S_STAT;
                    end
                end
            end
            S_FRONT:
            begin
                if (ack_reg == front_seq)
                begin
                    if (dup_reg != 2'd3)
                    begin
                        dup_next = dup_reg + 2'd1;
                    end
                    retire_next = 1'b0;
                    state_next  = S_STEP;
                end
                else if (ack_reg > front_seq)
                begin
                    dup_next   = '0;
                    state_next = S_RCHK;
                end
                else
                begin
                    state_next = S_STAT;
                end
            end
            S_RCHK:
            begin
                if (count_reg != '0 && front_seq < ack_reg)
                begin
                    retire_next = 1'b1;
                    state_next  = S_STEP;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_STEP:
            begin
                state_next = retire_reg ? S_RDW : S_STAT;
                priority if (mode_reg == tcprc_pkg::MODE_SS
                             && THR_W'(win_reg) >= thr_reg)
                begin
                    mode_next = tcprc_pkg::MODE_CA;
                end
                else if ((mode_reg == tcprc_pkg::MODE_SS || mode_reg == tcprc_pkg::MODE_CA)
                         && dup_reg == 2'd3)
                begin
                    mode_next = tcprc_pkg::MODE_FR;
                    thr_next  = THR_W'(win_reg >> 1);
                    win_next  = w_rec;
                    dup_next  = '0;
                    if (!retire_reg)
                    begin
                        state_next = S_RTX;
                    end
                end
                else if (mode_reg == tcprc_pkg::MODE_SS && dup_reg == '0)
                begin
                    win_next = w_inc;
                end
                else if (mode_reg == tcprc_pkg::MODE_CA && dup_reg == '0)
                begin
                    if (win_reg == '0)
                    begin
                        win_next = WMAX_FX;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVW;
                    end
                end
                else if (mode_reg == tcprc_pkg::MODE_FR)
                begin
                    if (dup_reg == '0)
                    begin
                        win_next  = w_thr;
                        mode_next = tcprc_pkg::MODE_CA;
                    end
                    else
                    begin
                        win_next = w_inc;
                    end
                end
                else
                begin
                    mode_next = mode_reg;
                end
                if (retire_reg)
                begin
                    head_next  = head_reg + QI'(1);
                    count_next = count_reg - CN'(1);
                end
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    win_next   = w_div;
                    state_next = retire_reg ? S_RCHK : S_STAT;
                end
            end
            S_RDW:
            begin
                state_next = S_RCHK;
            end
            S_FILL:
            begin
                if (!fcond)
                begin
                    state_next = sent_reg ? S_IDLE : S_STAT;
                end
                else if (out_free)
                begin
                    ram_we     = 1'b1;
                    ov_next    = 1'b1;
                    kind_next  = tcprc_pkg::KIND_NEW;
                    oseq_next  = nseq_reg;
                    olen_next  = flen;
                    olast_next = !fnext;
                    omode_next = mode_reg;
                    owin_next  = wwhole;
                    odone_next = 1'b0;
                    count_next = count_reg + CN'(1);
                    nseq_next  = nseq_reg + SW'(flen);
                    bleft_next = bafter;
                    sent_next  = 1'b1;
                    if (!fnext)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RTX:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    kind_next  = tcprc_pkg::KIND_RETX;
                    oseq_next  = front_seq;
                    olen_next  = front_len;
                    olast_next = 1'b1;
                    omode_next = mode_reg;
                    owin_next  = wwhole;
                    odone_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    kind_next  = tcprc_pkg::KIND_STATUS;
                    oseq_next  = '0;
                    olen_next  = '0;
                    olast_next = 1'b1;
                    omode_next = mode_reg;
                    owin_next  = wwhole;
                    odone_next = (bleft_reg == '0) && (count_reg == '0);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            win_reg    <= ONE_FX;
            thr_reg    <= THR_W'(7'd64) << FRAC_BITS;
            dup_reg    <= '0;
            mode_reg   <= tcprc_pkg::MODE_SS;
            nseq_reg   <= '0;
            bleft_reg  <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            retire_reg <= 1'b0;
            sent_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            total_reg  <= '0;
            segsz_reg  <= tcprc_pkg::MAX_SEG;
            ithr_reg   <= 7'd64;
        end
        else
        begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            thr_reg    <= thr_next;
            dup_reg    <= dup_next;
            mode_reg   <= mode_next;
            nseq_reg   <= nseq_next;
            bleft_reg  <= bleft_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            retire_reg <= retire_next;
            sent_reg   <= sent_next;
            ov_reg     <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tcprc_pkg::CFG_TOTAL)
                begin
                    total_reg <= cfg_data;
                end
                else if (cfg_index == tcprc_pkg::CFG_SEG)
                begin
                    segsz_reg <= cfg_data[LW-1:0];
                end
                else if (cfg_index == tcprc_pkg::CFG_THR)
                begin
                    ithr_reg <= cfg_data[6:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg   <= ack_next;
        kind_reg  <= kind_next;
        oseq_reg  <= oseq_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
        omode_reg <= omode_next;
        owin_reg  <= owin_next;
        odone_reg <= odone_next;
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign seq_out      = oseq_reg;
    assign length_out   = olen_reg;
    assign last         = olast_reg;
    assign mode_out     = omode_reg;
    assign window_whole = owin_reg;
    assign done_res     = odone_reg;

endmodule

/* rtl/tcprc_checker.sv */
// ----------------------------------------------------------------------------
// tcprc_checker
// port-level checks of the reno congestion sender results
// ----------------------------------------------------------------------------
`include "tcp_reno_congestion_sender_core_macros.svh"

module tcprc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [31:0] seq_out,
    input logic [9:0]  length_out,
    input logic        last,
    input logic        done_res
);

    `TRC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(seq_out))
    `TRC_ASSERT_NOW(a_status, out_valid && kind == tcprc_pkg::KIND_STATUS, seq_out == 32'd0 && length_out == 10'd0 && last)
    `TRC_ASSERT_NOW(a_retx_last, out_valid && kind == tcprc_pkg::KIND_RETX, last)
    `TRC_ASSERT_NOW(a_done_status, out_valid && done_res, kind == tcprc_pkg::KIND_STATUS)
    `TRC_ASSERT_NOW(a_new_len, out_valid && kind == tcprc_pkg::KIND_NEW, length_out != 10'd0)

endmodule

bind tcp_reno_congestion_sender_core tcprc_checker u_tcprc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .seq_out    (seq_out),
    .length_out (length_out),
    .last       (last),
    .done_res   (done_res)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the reno congestion sender core: start, ack and
// timeout events are generated against a shadow copy of the congestion state,
// the segment commands each event should cause are queued in order and every
// output transaction is checked field by field under random idling and stalls
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC     = 16;
    localparam int          MAXW     = 32;
    localparam logic [31:0] ONE_FX   = 32'd1 << FRAC;
    localparam logic [31:0] WMAX_FX  = MAXW << FRAC;
    localparam int          LIMIT    = 1500000;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] ack;
    } event_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [9:0]  len;
        logic        last;
        logic [1:0]  mode;
        logic [5:0]  ww;
        logic        done;
    } seg_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [31:0] ack_number = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] seq_out;
    logic [9:0]  length_out;
    logic        last;
    logic [1:0]  mode_out;
    logic [5:0]  window_whole;
    logic        done_res;

    tcp_reno_congestion_sender_core u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow congestion state
    logic [31:0] m_total = 32'd0;
    logic [9:0]  m_seg = tcprc_pkg::MAX_SEG;
    logic [6:0]  m_ithr = 7'd64;
    logic [31:0] m_win = ONE_FX;
    logic [31:0] m_thr = 32'd64 << FRAC;
    logic [1:0]  m_dup = '0;
    logic [1:0]  m_mode = tcprc_pkg::MODE_SS;
    logic [31:0] m_next = '0;
    logic [31:0] m_left = '0;
    logic [31:0] m_pseq [tcprc_pkg::QDEPTH];
    logic [9:0]  m_plen [tcprc_pkg::QDEPTH];
    int unsigned m_head = 0;
    int unsigned m_count = 0;

    event_t   pend_events[$];
    seg_cmd_t expected_cmds[$];

    int unsigned errors = 0;
    int unsigned n_events = 0;
    int unsigned n_cmds = 0;
    int unsigned cycles = 0;
    int unsigned p_send_idle = 0;
    int unsigned p_recv_stall = 0;
    bit          hold_req = 0;
    int unsigned hold_left = 0;
    bit          in_taken = 0;
    bit          showing = 0;

    function automatic logic [31:0] sat_win(logic [63:0] v);
        return (v > WMAX_FX) ? WMAX_FX : v[31:0];
    endfunction

    function automatic void enter_recovery();
        m_mode = tcprc_pkg::MODE_FR;
        m_thr  = m_win >> 1;
        m_win  = sat_win(64'(m_thr) + 3 * 64'(ONE_FX));
        m_dup  = '0;
    endfunction

    function automatic bit window_step();
        case (m_mode)
            tcprc_pkg::MODE_SS:
            begin
                if (m_win >= m_thr)
                begin
                    m_mode = tcprc_pkg::MODE_CA;
                    return 0;
                end
                if (m_dup == 2'd3)
                begin
                    enter_recovery();
                    return 1;
                end
                if (m_dup == 2'd0)
                    m_win = sat_win(64'(m_win) + ONE_FX);
            end
            tcprc_pkg::MODE_CA:
            begin
                if (m_dup == 2'd3)
                begin
                    enter_recovery();
                    return 1;
                end
                if (m_dup == 2'd0)
                begin
                    if (m_win == 0)
                        m_win = WMAX_FX;
                    else
                        m_win = sat_win(64'(m_win) + (64'h1_0000_0000 / 64'(m_win)));
                end
            end
            tcprc_pkg::MODE_FR:
            begin
                if (m_dup == 2'd0)
                begin
                    m_win  = sat_win(64'(m_thr));
                    m_mode = tcprc_pkg::MODE_CA;
                end
                else
                    m_win = sat_win(64'(m_win) + ONE_FX);
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic seg_cmd_t mk_cmd(logic [1:0] k, logic [31:0] s, logic [9:0] l);
        seg_cmd_t c;
        c.kind = k;
        c.seq  = s;
        c.len  = l;
        c.last = 0;
        c.mode = '0;
        c.ww   = '0;
        c.done = 0;
        return c;
    endfunction

    function automatic void fill_window(ref seg_cmd_t cmds[$]);
        logic [63:0] used;
        logic [63:0] need;
        logic [31:0] seg;
        logic [31:0] len;
        int unsigned t;
        used = 64'(m_count) << FRAC;
        seg  = (m_seg > tcprc_pkg::MAX_SEG) ? 32'(tcprc_pkg::MAX_SEG) : 32'(m_seg);
        if (64'(m_win) <= used)
            return;
        need = (64'(m_win) - used + ONE_FX - 1) >> FRAC;
        for (int i = 0; i < need && m_count < tcprc_pkg::QDEPTH; i++)
        begin
            len = (m_left < seg) ? m_left : seg;
            if (len == 0)
                break;
            t = (m_head + m_count) % tcprc_pkg::QDEPTH;
            m_pseq[t] = m_next;
            m_plen[t] = len[9:0];
            m_count++;
            cmds.push_back(mk_cmd(tcprc_pkg::KIND_NEW, m_next, len[9:0]));
            m_next += len;
            m_left -= len;
        end
    endfunction

    // queue the event and the segment commands it should cause
    function automatic void push_event(logic [1:0] req, logic [31:0] ack);
        seg_cmd_t cmds[$];
        event_t   ev;
        logic [31:0] front;
        ev.req = req;
        ev.ack = ack;
        pend_events.push_back(ev);
        if (req == tcprc_pkg::REQ_START)
        begin
            m_win   = ONE_FX;
            m_thr   = 32'(m_ithr) << FRAC;
            m_dup   = '0;
            m_mode  = tcprc_pkg::MODE_SS;
            m_next  = '0;
            m_left  = m_total;
            m_head  = 0;
            m_count = 0;
            fill_window(cmds);
        end
        else if (req == tcprc_pkg::REQ_ACK && m_count > 0)
        begin
            front = m_pseq[m_head];
            if (ack == front)
            begin
                if (m_dup != 2'd3)
                    m_dup++;
                if (window_step())
                    cmds.push_back(mk_cmd(tcprc_pkg::KIND_RETX, m_pseq[m_head],
                                          m_plen[m_head]));
            end
            else if (ack > front)
            begin
                m_dup = '0;
                while (m_count > 0 && m_pseq[m_head] < ack)
                begin
                    void'(window_step());
                    m_head = (m_head + 1) % tcprc_pkg::QDEPTH;
                    m_count--;
                end
                fill_window(cmds);
            end
        end
        else if (req == tcprc_pkg::REQ_TMO && m_count > 0)
        begin
            m_thr  = m_win >> 1;
            m_win  = ONE_FX;
            m_dup  = '0;
            m_mode = tcprc_pkg::MODE_SS;
            cmds.push_back(mk_cmd(tcprc_pkg::KIND_RETX, m_pseq[m_head], m_plen[m_head]));
        end
        if (cmds.size() == 0)
            cmds.push_back(mk_cmd(tcprc_pkg::KIND_STATUS, '0, '0));
        foreach (cmds[k])
        begin
            cmds[k].last = (k == cmds.size() - 1);
            cmds[k].mode = m_mode;
            cmds[k].ww   = m_win[FRAC+5:FRAC];
            cmds[k].done = (m_left == 0 && m_count == 0);
            expected_cmds.push_back(cmds[k]);
        end
    endfunction

    // ack that retires between one and all outstanding segments
    function automatic logic [31:0] retiring_ack(bit all_of_them);
        int unsigned k;
        if (all_of_them)
            return m_next;
        k = $urandom_range(1, (m_count > 3) ? 3 : m_count);
        if (k == m_count)
            return m_next;
        return m_pseq[(m_head + k) % tcprc_pkg::QDEPTH];
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            tcprc_pkg::CFG_TOTAL: m_total = val;
            tcprc_pkg::CFG_SEG:   m_seg   = val[9:0];
            tcprc_pkg::CFG_THR:   m_ithr  = val[6:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pend_events.size() != 0 || expected_cmds.size() != 0 || showing)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic gen_events(int unsigned n);
        int unsigned r;
        push_event(tcprc_pkg::REQ_START, '0);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (m_count == 0)
            begin
                if (r < 85)
                    push_event(tcprc_pkg::REQ_START, '0);
                else
                    push_event(2'($urandom_range(3)), $urandom);
            end
            else if (r < 55)
                push_event(tcprc_pkg::REQ_ACK, retiring_ack(r < 12));
            else if (r < 70)
                push_event(tcprc_pkg::REQ_ACK, m_pseq[m_head]);
            else if (r < 78)
                push_event(tcprc_pkg::REQ_TMO, $urandom);
            else if (r < 82)
                push_event(tcprc_pkg::REQ_START, $urandom);
            else if (r < 87)
                push_event(tcprc_pkg::REQ_ACK, (m_pseq[m_head] == 0) ? 32'd0 :
                           32'($urandom_range(0, m_pseq[m_head] - 1)));
            else if (r < 91)
                push_event(2'd3, $urandom);
            else
                push_event(tcprc_pkg::REQ_ACK, $urandom);
        end
    endtask

    // transaction acceptance, sampled at the rising edge
    always @(posedge clk)
    begin
        seg_cmd_t e;
        cycles++;
        in_taken = in_valid && !in_stall;
        if (in_taken)
            n_events++;
        if (out_valid && !out_stall)
        begin
            n_cmds++;
            if (expected_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transaction kind %0d seq %0d",
                         $time, kind, seq_out);
            end
            else
            begin
                e = expected_cmds.pop_front();
                if (kind !== e.kind || seq_out !== e.seq || length_out !== e.len ||
                    last !== e.last || mode_out !== e.mode || window_whole !== e.ww ||
                    done_res !== e.done)
                begin
                    errors++;
                    $display("%0t: mismatch expected kind %0d seq %0d len %0d last %0d mode %0d win %0d done %0d",
                             $time, e.kind, e.seq, e.len, e.last, e.mode, e.ww, e.done);
                    $display("%0t:          actual   kind %0d seq %0d len %0d last %0d mode %0d win %0d done %0d",
                             $time, kind, seq_out, length_out, last, mode_out,
                             window_whole, done_res);
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // event driver
    always @(negedge clk)
    begin
        if (showing && in_taken)
        begin
            void'(pend_events.pop_front());
            showing = 0;
        end
        if (!showing && rst_n && pend_events.size() != 0 &&
            $urandom_range(99) >= p_send_idle)
            showing = 1;
        in_valid <= showing;
        if (showing)
        begin
            req_type   <= pend_events[0].req;
            ack_number <= pend_events[0].ack;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= 700;
            hold_req = 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
        out_stall <= (hold_left != 0) || ($urandom_range(99) < p_recv_stall);

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: empty session
        push_event(tcprc_pkg::REQ_START, '0);
        push_event(tcprc_pkg::REQ_ACK, 32'hFFFF_FFFF);
        push_event(tcprc_pkg::REQ_TMO, '0);
        wait_idle();

        write_reg(tcprc_pkg::CFG_TOTAL, 32'd4500);
        write_reg(tcprc_pkg::CFG_SEG, 32'd1000);
        write_reg(tcprc_pkg::CFG_THR, 32'd2);
        push_event(tcprc_pkg::REQ_START, '0);
        push_event(tcprc_pkg::REQ_ACK, m_pseq[m_head]);
        push_event(tcprc_pkg::REQ_ACK, m_pseq[m_head]);
        push_event(tcprc_pkg::REQ_ACK, m_pseq[m_head]);
        push_event(tcprc_pkg::REQ_ACK, m_pseq[m_head]);
        push_event(tcprc_pkg::REQ_ACK, retiring_ack(0));
        push_event(tcprc_pkg::REQ_TMO, '0);
        push_event(tcprc_pkg::REQ_TMO, 32'hFFFF_FFFF);
        push_event(tcprc_pkg::REQ_ACK, (m_pseq[m_head] == 0) ? 32'd0 : m_pseq[m_head] - 1);
        push_event(2'd3, 32'hFFFF_FFFF);
        push_event(tcprc_pkg::REQ_ACK, retiring_ack(1));
        push_event(tcprc_pkg::REQ_ACK, retiring_ack(1));
        push_event(tcprc_pkg::REQ_ACK, retiring_ack(1));
        push_event(tcprc_pkg::REQ_ACK, 32'hFFFF_FFFF);
        push_event(tcprc_pkg::REQ_TMO, '0);
        push_event(tcprc_pkg::REQ_ACK, 32'h0000_0001);
        wait_idle();

        write_reg(tcprc_pkg::CFG_SEG, 32'd0);
        push_event(tcprc_pkg::REQ_START, '0);
        push_event(tcprc_pkg::REQ_ACK, '0);
        wait_idle();
        write_reg(tcprc_pkg::CFG_SEG, 32'd1023);
        write_reg(tcprc_pkg::CFG_THR, 32'd127);
        write_reg(tcprc_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
        // grow to a full outstanding queue
        push_event(tcprc_pkg::REQ_START, '0);
        for (int i = 0; i < 6; i++)
            push_event(tcprc_pkg::REQ_ACK, retiring_ack(1));
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            p_send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? 77 : 0;
            p_recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? 77 : 0;
            if (ph % 4 == 3)
            begin
                p_send_idle  = 6;
                p_recv_stall = 6;
            end
            case (ph)
                0: begin write_reg(tcprc_pkg::CFG_TOTAL, 32'd30000);
                         write_reg(tcprc_pkg::CFG_SEG, 32'd1000);
                         write_reg(tcprc_pkg::CFG_THR, 32'd64); end
                1: begin write_reg(tcprc_pkg::CFG_TOTAL, 32'd2000);
                         write_reg(tcprc_pkg::CFG_SEG, 32'd1);
                         write_reg(tcprc_pkg::CFG_THR, 32'd1); end
                2: begin write_reg(tcprc_pkg::CFG_TOTAL, 32'hFFFF_FFFF);
                         write_reg(tcprc_pkg::CFG_SEG, 32'd1000);
                         write_reg(tcprc_pkg::CFG_THR, 32'd8); end
                default:
                begin
                    write_reg(tcprc_pkg::CFG_TOTAL, ($urandom_range(3) == 0) ? $urandom
                                                    : $urandom_range(0, 60000));
                    write_reg(tcprc_pkg::CFG_SEG, $urandom_range(0, 1023));
                    write_reg(tcprc_pkg::CFG_THR, $urandom_range(0, 127));
                end
            endcase
            gen_events(18);
            if (ph == 2)
                hold_req = 1;
            // pause the sender mid-phase until everything has come back
            while (expected_cmds.size() != 0)
                @(posedge clk);
            gen_events(18);
            wait_idle();
        end

        $display("run covered %0d events and %0d segment commands over several settings",
                 n_events, n_cmds);
        $display("with slow start, avoidance, fast recovery, timeouts and full queue");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/tcprc_pkg.sv
rtl/tcprc_ram.sv
rtl/tcprc_div.sv
rtl/tcp_reno_congestion_sender_core.sv
rtl/tcprc_checker.sv
tb/tb_top.sv
